>>> design/abes_pkg.sv
// ----------------------------------------------------------------------------
// abes_pkg: shared types and constants for the box step core
// Command codes, table geometry and field widths.
// ----------------------------------------------------------------------------
package abes_pkg;

    localparam int NumSlots  = 64;
    localparam int SlotW     = $clog2(NumSlots);
    localparam int CountW    = SlotW + 1;
    localparam int ExtentMul = 10;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // 37-bit span value: 32-bit Q16.16 plus 10x growth plus the position add
    localparam int SpanW = 37;
    typedef logic signed [SpanW-1:0] span_t;

endpackage

>>> design/abes_mac.sv
// ----------------------------------------------------------------------------
// abes_mac: one Euler update term
// Registers base + round(val * dt) with saturation to the signed 32-bit range.
// ----------------------------------------------------------------------------
module abes_mac (
    input  logic               aclk,
    input  logic signed [31:0] base,
    input  logic signed [31:0] val,
    input  logic        [15:0] dt,
    output logic signed [31:0] sum_reg,
    output logic               sat_reg
);

    logic signed [48:0] prod_reg;
    logic signed [31:0] base_reg;
    logic signed [48:0] rnd;
    // rnd >>> 16 fits 33 bits; use bits [48:16] sign-extended
    logic signed [33:0] term;
    logic signed [33:0] tot;

    always_ff @(posedge aclk) begin
        prod_reg <= val * $signed({1'b0, dt});
        base_reg <= base;
    end

    always_comb begin
        rnd = prod_reg + 49'sd32768;
    end

    assign term = {rnd[48], rnd[48:16]};
    assign tot  = {{2{base_reg[31]}}, base_reg} + term;

    always_ff @(posedge aclk) begin
        if (tot > 34'sd2147483647) begin
            sum_reg <= 32'sh7fffffff;
            sat_reg <= 1'b1;
        end else if (tot < -34'sd2147483648) begin
            sum_reg <= 32'sh80000000;
            sat_reg <= 1'b1;
        end else begin
            sum_reg <= tot[31:0];
            sat_reg <= 1'b0;
        end
    end

endmodule

>>> design/aabb_blocked_euler_step_core.sv
// ----------------------------------------------------------------------------
// aabb_blocked_euler_step_core: box table with collision-held Euler step
// Usage:
//   s_axis carries one request (write slot, step, read slot); m_axis returns
//   exactly one result per request. cfg_* writes active_objects; the user
//   must do so only while idle, as the core does not enforce it. A write
//   answers in the cycle after it is accepted, a read after ST_RDS and ST_RDS2.
//   A step visits every active slot i through ST_RDI and ST_LDI; a static
//   box goes straight to ST_NEXT, any other reads every other active slot j
//   from the table memory in ST_RDJ and ST_CMPJ, one j at a time through the
//   single table read port, testing all four corners of i against j's span.
//   A held box then goes to ST_NEXT, one that moves passes ST_UPD0..ST_UPD4
//   and ST_OUT in the shared update unit. s_tready is low while a request is
//   in work or its result waits; a stalled receiver holds the result
//   register and the core. Reset clears the control state, active_objects
//   and the held flags; the table contents are undefined until written.
// ----------------------------------------------------------------------------
module aabb_blocked_euler_step_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[1:0], slot[7:2], pos_x, pos_y, vel_x, vel_y, acc_x, acc_y,
    // size_x, size_y (32 each from bit 8), fixed_flag[264], frame_time[280:265]
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_pos_x[31:0], out_pos_y, out_vel_x, out_vel_y, out_fixed[128],
    // out_blocked[129], blocked_count[136:130], saturated[137]
    output logic [143:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [6:0]   cfg_data
);

    localparam int SW = abes_pkg::SlotW;
    localparam int CW = abes_pkg::CountW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RDI, ST_LDI, ST_RDJ, ST_CMPJ, ST_UPD0, ST_UPD1,
        ST_UPD2, ST_UPD3, ST_UPD4, ST_NEXT, ST_RDS, ST_RDS2, ST_OUT
    } state_t;

    // table: pos x/y, vel x/y, acc x/y, size x/y, static
    logic [256:0] tbl_mem [abes_pkg::NumSlots];
    logic [abes_pkg::NumSlots-1:0] held_reg;

    state_t state_reg;
    logic [CW-1:0] active_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] i_reg, j_reg;
    logic [SW-1:0] rd_addr;
    logic [256:0] rd_reg;
    logic [256:0] me_reg;
    logic [15:0] dt_reg;
    logic [CW-1:0] cnt_reg;
    logic sat_reg, hit_reg;
    logic [143:0] out_reg;
    logic out_valid_reg;
    logic in_step_reg;

    // corners of box i; the span of box j is formed combinationally below
    abes_pkg::span_t cx0_reg, cx1_reg, cy0_reg, cy1_reg;

    function automatic abes_pkg::span_t ext(input logic signed [31:0] s);
        abes_pkg::span_t v;
        v = abes_pkg::SpanW'(s);
        return (v <<< 3) + (v <<< 1);
    endfunction

    abes_pkg::span_t jax, jay, jbx, jby, jlx, jhx, jly, jhy;
    logic inx0, inx1, iny0, iny1, hit_j;
    always_comb begin
        jax = abes_pkg::SpanW'($signed(rd_reg[31:0]));
        jay = abes_pkg::SpanW'($signed(rd_reg[63:32]));
        jbx = jax + ext(rd_reg[223:192]);
        jby = jay + ext(rd_reg[255:224]);
        jlx = (jax < jbx) ? jax : jbx;
        jhx = (jax < jbx) ? jbx : jax;
        jly = (jay < jby) ? jay : jby;
        jhy = (jay < jby) ? jby : jay;
        inx0 = (cx0_reg > jlx) && (cx0_reg < jhx);
        inx1 = (cx1_reg > jlx) && (cx1_reg < jhx);
        iny0 = (cy0_reg > jly) && (cy0_reg < jhy);
        iny1 = (cy1_reg > jly) && (cy1_reg < jhy);
        hit_j = (inx0 || inx1) && (iny0 || iny1);
    end

    // shared update unit
    logic signed [31:0] mac_base, mac_val, mac_sum;
    logic mac_sat;
    logic upd_vel;
    logic upd_y;
    assign mac_base = upd_vel ? (upd_y ? me_reg[127:96] : me_reg[95:64])
                              : (upd_y ? me_reg[63:32]  : me_reg[31:0]);
    assign mac_val  = upd_vel ? (upd_y ? me_reg[191:160] : me_reg[159:128])
                              : (upd_y ? me_reg[127:96]  : me_reg[95:64]);

    abes_mac u_mac (
        .aclk    (aclk),
        .base    (mac_base),
        .val     (mac_val),
        .dt      (dt_reg),
        .sum_reg (mac_sum),
        .sat_reg (mac_sat)
    );

    logic s_acc;
    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    abes_pkg::cmd_t in_cmd;
    logic [SW-1:0] in_slot;
    assign in_cmd  = abes_pkg::cmd_t'(s_tdata[1:0]);
    assign in_slot = s_tdata[7:2];

    always_comb begin
        unique case (state_reg)
            ST_RDI:  rd_addr = i_reg[SW-1:0];
            ST_RDS:  rd_addr = i_reg[SW-1:0];
            default: rd_addr = j_reg[SW-1:0];
        endcase
    end

    // table write port
    logic wr_en;
    logic [SW-1:0] wr_addr;
    logic [256:0] wr_data;
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = i_reg[SW-1:0];
        wr_data = me_reg;
        if (s_acc && in_cmd == abes_pkg::CMD_WRITE) begin
            wr_en   = 1'b1;
            wr_addr = in_slot;
            wr_data = s_tdata[264:8];
        end else if (state_reg == ST_NEXT && !hit_reg && !me_reg[256]) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tbl_mem[wr_addr] <= wr_data;
        end
        rd_reg <= tbl_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                active_reg <= cfg_data;
            end
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        out_reg <= '0;
                        unique case (in_cmd)
                            abes_pkg::CMD_WRITE: begin
                                out_valid_reg <= 1'b1;
                            end
                            abes_pkg::CMD_STEP: begin
                                dt_reg   <= s_tdata[280:265];
                                n_reg    <= (active_reg > CW'(abes_pkg::NumSlots))
                                            ? CW'(abes_pkg::NumSlots) : active_reg;
                                i_reg    <= '0;
                                cnt_reg  <= '0;
                                sat_reg  <= 1'b0;
                                held_reg <= '0;
                                state_reg <= ST_NEXT;
                                hit_reg  <= 1'b1;
                                me_reg[256] <= 1'b1;
                            end
                            abes_pkg::CMD_READ: begin
                                i_reg     <= CW'(in_slot);
                                state_reg <= ST_RDS;
                            end
                            abes_pkg::CMD_NONE: begin
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_RDS: state_reg <= ST_RDS2;
                ST_RDS2: begin
                    out_reg[127:0]  <= rd_reg[127:0];
                    out_reg[128]    <= rd_reg[256];
                    out_reg[129]    <= held_reg[i_reg[SW-1:0]];
                    out_valid_reg   <= 1'b1;
                    state_reg       <= ST_IDLE;
                end
                ST_RDI: state_reg <= ST_LDI;
                ST_LDI: begin
                    me_reg  <= rd_reg;
                    cx0_reg <= abes_pkg::SpanW'($signed(rd_reg[31:0]));
                    cy0_reg <= abes_pkg::SpanW'($signed(rd_reg[63:32]));
                    cx1_reg <= abes_pkg::SpanW'($signed(rd_reg[31:0]))
                               + ext(rd_reg[223:192]);
                    cy1_reg <= abes_pkg::SpanW'($signed(rd_reg[63:32]))
                               + ext(rd_reg[255:224]);
                    hit_reg <= 1'b0;
                    j_reg   <= '0;
                    state_reg <= rd_reg[256] ? ST_NEXT : ST_RDJ;
                end
                ST_RDJ: begin
                    // skip self and stop at the end of the active range
                    if (j_reg == n_reg) begin
                        state_reg <= hit_reg ? ST_NEXT : ST_UPD0;
                    end else if (j_reg == i_reg) begin
                        j_reg <= j_reg + 1'b1;
                    end else begin
                        state_reg <= ST_CMPJ;
                    end
                end
                ST_CMPJ: begin
                    hit_reg   <= hit_reg | hit_j;
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= ST_RDJ;
                end
                ST_UPD0: state_reg <= ST_UPD1;
                ST_UPD1: state_reg <= ST_UPD2;
                ST_UPD2: begin
                    me_reg[31:0] <= mac_sum;
                    sat_reg      <= sat_reg | mac_sat;
                    state_reg    <= ST_UPD3;
                end
                ST_UPD3: begin
                    me_reg[63:32] <= mac_sum;
                    sat_reg       <= sat_reg | mac_sat;
                    state_reg     <= ST_UPD4;
                end
                ST_UPD4: begin
                    // velocity terms come out of the same unit registers as the position terms
                    me_reg[95:64] <= mac_sum;
                    sat_reg       <= sat_reg | mac_sat;
                    state_reg     <= ST_OUT;
                end
                ST_OUT: begin
                    me_reg[127:96] <= mac_sum;
                    sat_reg        <= sat_reg | mac_sat;
                    state_reg      <= ST_NEXT;
                end
                ST_NEXT: begin
                    if (hit_reg && !me_reg[256] && in_step_reg) begin
                        held_reg[i_reg[SW-1:0]] <= 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (in_step_reg) begin
                        i_reg <= i_reg + 1'b1;
                    end
                    if ((in_step_reg ? i_reg + 1'b1 : i_reg) >= n_reg) begin
                        out_reg[136:130] <= (hit_reg && !me_reg[256] && in_step_reg)
                                            ? cnt_reg + 1'b1 : cnt_reg;
                        out_reg[137]     <= sat_reg;
                        out_valid_reg    <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end else begin
                        state_reg <= ST_RDI;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // first-visit marker: low until the first box of a step is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_step_reg <= 1'b0;
        end else begin
            if (state_reg == ST_IDLE) begin
                in_step_reg <= 1'b0;
            end else if (state_reg == ST_LDI) begin
                in_step_reg <= 1'b1;
            end
        end
    end

    // unit schedule: pos x, pos y, vel x, vel y issued on UPD0..UPD3
    always_comb begin
        upd_vel = (state_reg == ST_UPD2) || (state_reg == ST_UPD3);
        upd_y   = (state_reg == ST_UPD1) || (state_reg == ST_UPD3);
    end

endmodule
